/* design/tmc_pkg.sv */
// Shared constants and types for the touch trimmed-mean calibrator.
// No dependencies; imported by every module of the block.
package tmc_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 14;
  localparam int COORD_MAX  = 4095;

  localparam int BURST_LEN_DEF  = 15;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RAW_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_CENTER_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_CENTER_Y = 3'd5;

  localparam logic [SAMPLE_W-1:0]      RAW_CENTER_RST = 12'd2048;
  localparam logic signed [GAIN_W-1:0] GAIN_RST       = 16'sd1280;
  localparam logic [SAMPLE_W-1:0]      SCREEN_X_RST   = 12'd180;
  localparam logic [SAMPLE_W-1:0]      SCREEN_Y_RST   = 12'd120;

  // Calibration set of one axis
  typedef struct packed {
    logic [SAMPLE_W-1:0]      raw_center;
    logic signed [GAIN_W-1:0] gain;
    logic [SAMPLE_W-1:0]      screen_center;
  } cal_t;

  // Queue handshake between the accumulator and the mapping pipeline
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

/* design/tmc_front.sv */
// Front end: takes sample beats, keeps count, sum, max and min of a burst,
// and pushes the trimmed sum with its axis at burst end. Uses tmc_pkg.
module tmc_front
  import tmc_pkg::*;
#(
  parameter int BURST_LEN = BURST_LEN_DEF,
  parameter int SUM_W     = $clog2(BURST_LEN * (1 << SAMPLE_W))
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                axis,
  input  logic                queue_full,
  output logic                push,
  output logic                push_axis,
  output logic [SUM_W-1:0]    push_sum
);

  localparam int CNT_W = $clog2(BURST_LEN);

  logic [CNT_W-1:0]    burst_count;
  logic [SUM_W-1:0]    running_sum;
  logic [SAMPLE_W-1:0] largest_seen;
  logic [SAMPLE_W-1:0] smallest_seen;

  logic [SUM_W-1:0]    sum_next;
  logic [SAMPLE_W-1:0] largest_next;
  logic [SAMPLE_W-1:0] smallest_next;
  logic                accept;
  logic                last;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign last     = (burst_count == CNT_W'(BURST_LEN - 1));

  always_comb begin
    sum_next      = running_sum + SUM_W'(sample);
    largest_next  = (sample > largest_seen) ? sample : largest_seen;
    smallest_next = (sample < smallest_seen) ? sample : smallest_seen;
  end

  assign push      = accept && last;
  assign push_axis = axis;
  assign push_sum  = sum_next - SUM_W'(largest_next) - SUM_W'(smallest_next);

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      burst_count   <= '0;
      running_sum   <= '0;
      largest_seen  <= '0;
      smallest_seen <= '1;
    end else if (accept) begin
      burst_count   <= burst_count + CNT_W'(1);
      running_sum   <= sum_next;
      largest_seen  <= largest_next;
      smallest_seen <= smallest_next;
    end
  end

endmodule

/* design/tmc_queue.sv */
// Small FIFO between the burst accumulator and the mapping pipeline.
// Uses tmc_pkg for the status struct.
module tmc_queue
  import tmc_pkg::*;
#(
  parameter int WIDTH = 2,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output queue_status_t    status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign status.full  = (fill == CNT_W'(DEPTH));
  assign status.valid = (fill != '0);
  assign pop_data     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

/* design/tmc_back.sv */
// Back end: divides the trimmed sum by BURST_LEN-2 (reciprocal multiply),
// applies the Q2.14 gain, clamps, and holds the result beat. Uses tmc_pkg.
module tmc_back
  import tmc_pkg::*;
#(
  parameter int BURST_LEN = BURST_LEN_DEF,
  parameter int SUM_W     = $clog2(BURST_LEN * (1 << SAMPLE_W))
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                pop,
  input  logic                q_axis,
  input  logic [SUM_W-1:0]    q_sum,
  input  cal_t                cal_x,
  input  cal_t                cal_y,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                axis_out,
  output logic [SAMPLE_W-1:0] mean_raw,
  output logic [SAMPLE_W-1:0] coordinate
);

  // floor(x / DIV) == (x * RECIP) >> SHIFT exactly for every x < 2^SUM_W
  localparam int DIV     = BURST_LEN - 2;
  localparam int L       = $clog2(DIV);
  localparam int SHIFT   = SUM_W + L;
  localparam int RECIP_W = SUM_W + 1;
  localparam int P1_W    = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + DIV - 1) / DIV;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_L[RECIP_W-1:0];

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int P2_W   = DIFF_W + GAIN_W;
  localparam int Q_W    = P2_W - GAIN_FRAC;
  localparam int POS_W  = Q_W + 2;

  // stage 1: reciprocal product
  logic            v1;
  logic            ax1;
  logic [P1_W-1:0] prod1;
  // stage 2: gain product
  logic                   v2;
  logic                   ax2;
  logic [SAMPLE_W-1:0]    mean2;
  logic signed [P2_W-1:0] prod2;

  logic en_out;
  logic en2;
  logic en1;

  logic [SAMPLE_W-1:0]     mean1;
  cal_t                    cal1;
  cal_t                    cal2;
  logic signed [DIFF_W-1:0] diff1;

  logic                    neg;
  logic [P2_W-1:0]         mag;
  logic [Q_W-1:0]          q;
  logic signed [POS_W-1:0] qs;
  logic signed [POS_W-1:0] pos;
  logic [SAMPLE_W-1:0]     coord_next;

  assign en_out = !out_valid || out_ready;
  assign en2    = !v2 || en_out;
  assign en1    = !v1 || en2;
  assign pop    = q_valid && en1;

  assign mean1 = prod1[SHIFT +: SAMPLE_W];
  assign cal1  = ax1 ? cal_y : cal_x;
  assign diff1 = $signed({1'b0, mean1}) - $signed({1'b0, cal1.raw_center});
  assign cal2  = ax2 ? cal_y : cal_x;

  // truncate toward zero: shift the magnitude, then restore the sign
  always_comb begin
    neg = prod2[P2_W-1];
    mag = neg ? P2_W'(-prod2) : P2_W'(prod2);
    q   = mag[GAIN_FRAC +: Q_W];
    qs  = $signed({2'b00, q});
    pos = $signed(POS_W'({1'b0, cal2.screen_center})) + (neg ? -qs : qs);
    if (pos < 0) begin
      coord_next = '0;
    end else if (pos > POS_W'(COORD_MAX)) begin
      coord_next = SAMPLE_W'(COORD_MAX);
    end else begin
      coord_next = pos[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= pop;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en_out) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ax1   <= q_axis;
      prod1 <= P1_W'(q_sum) * P1_W'(RECIP);
    end
    if (en2) begin
      ax2   <= ax1;
      mean2 <= mean1;
      prod2 <= P2_W'(diff1) * P2_W'(cal1.gain);
    end
    if (en_out) begin
      axis_out   <= ax2;
      mean_raw   <= mean2;
      coordinate <= coord_next;
    end
  end

endmodule

/* design/touch_trimmed_mean_calibrator_top.sv */
// Top level of the touch trimmed-mean calibrator: configuration registers,
// accumulator front end, queue and mapping back end. Uses tmc_pkg.
//
// Samples stream in at one beat per clock; the front end only drops s_tready
// when the burst queue (QUEUE_DEPTH entries) is full because the result side
// is stalled. Every BURST_LEN samples give one result beat: the trimmed mean
// (largest and smallest removed, divided by BURST_LEN-2) and the calibrated,
// clamped screen coordinate, using the calibration set of the axis on the
// burst's last sample. After the last sample is taken, the result passes the
// reciprocal multiply, gain multiply and output registers in turn (the queue
// write happens on the same edge as the last sample).
// Configuration writes are always accepted; write them only while idle.
module touch_trimmed_mean_calibrator_top
  import tmc_pkg::*;
#(
  parameter int BURST_LEN   = BURST_LEN_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [11:0] sample, rest zero
  input  logic                  s_tuser,   // [0] axis
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // [11:0] mean_raw, [23:12] coordinate
  output logic                  m_tuser,   // [0] axis_out
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SUM_W = $clog2(BURST_LEN * (1 << SAMPLE_W));
  localparam int REC_W = SUM_W + 1;

  cal_t cal_x;
  cal_t cal_y;

  logic             push;
  logic             push_axis;
  logic [SUM_W-1:0] push_sum;
  logic             pop;
  logic [REC_W-1:0] pop_data;
  queue_status_t    qstat;
  logic [SAMPLE_W-1:0] mean_raw;
  logic [SAMPLE_W-1:0] coordinate;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_x.raw_center    <= RAW_CENTER_RST;
      cal_y.raw_center    <= RAW_CENTER_RST;
      cal_x.gain          <= GAIN_RST;
      cal_y.gain          <= GAIN_RST;
      cal_x.screen_center <= SCREEN_X_RST;
      cal_y.screen_center <= SCREEN_Y_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RAW_CENTER_X:    cal_x.raw_center    <= cfg_data[SAMPLE_W-1:0];
        REG_RAW_CENTER_Y:    cal_y.raw_center    <= cfg_data[SAMPLE_W-1:0];
        REG_GAIN_X:          cal_x.gain          <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_Y:          cal_y.gain          <= $signed(cfg_data[GAIN_W-1:0]);
        REG_SCREEN_CENTER_X: cal_x.screen_center <= cfg_data[SAMPLE_W-1:0];
        REG_SCREEN_CENTER_Y: cal_y.screen_center <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  tmc_front #(
    .BURST_LEN (BURST_LEN),
    .SUM_W     (SUM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .sample     (s_tdata[SAMPLE_W-1:0]),
    .axis       (s_tuser),
    .queue_full (qstat.full),
    .push       (push),
    .push_axis  (push_axis),
    .push_sum   (push_sum)
  );

  tmc_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_axis, push_sum}),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (qstat)
  );

  tmc_back #(
    .BURST_LEN (BURST_LEN),
    .SUM_W     (SUM_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (qstat.valid),
    .pop        (pop),
    .q_axis     (pop_data[SUM_W]),
    .q_sum      (pop_data[SUM_W-1:0]),
    .cal_x      (cal_x),
    .cal_y      (cal_y),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .axis_out   (m_tuser),
    .mean_raw   (mean_raw),
    .coordinate (coordinate)
  );

  assign m_tdata = {coordinate, mean_raw};

endmodule

/* bench/tmc_result_checker.sv */
// Scoreboard for the touch trimmed-mean calibrator: watches the sample, result
// and register channels, predicts each result beat and compares it.
// Depends on tmc_pkg; instantiated by touch_trimmed_mean_calibrator_top_tb.
module tmc_result_checker
  import tmc_pkg::*;
#(
  parameter int BURST_LEN = BURST_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [11:0] sample, rest zero
  input  logic                  s_tuser,   // [0] axis
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [23:0]           m_tdata,   // [11:0] mean_raw, [23:12] coordinate
  input  logic                  m_tuser,   // [0] axis_out
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct {
    logic                axis;
    logic [SAMPLE_W-1:0] mean_raw;
    logic [SAMPLE_W-1:0] coordinate;
  } touch_point_t;

  touch_point_t        point_q[$];
  cal_t                cal_x, cal_y;
  int unsigned         burst_taken;
  int unsigned         burst_sum;
  logic [SAMPLE_W-1:0] burst_max, burst_min;
  int                  fail_count = 0;

  assign mismatches = fail_count;

  task automatic flag_mismatch(input string msg);
    $display("%0t tmc_result_checker: %s", $time, msg);
    fail_count++;
  endtask

  // offset times Q2.14 gain, truncated toward zero, then clamped to the screen
  function automatic logic [SAMPLE_W-1:0] screen_coord(input logic [SAMPLE_W-1:0] avg,
                                                       input cal_t cal);
    longint offset, prod, step, pos;
    offset = longint'(avg) - longint'(cal.raw_center);
    prod   = offset * longint'($signed(cal.gain));
    if (prod < 0) step = -((-prod) >> GAIN_FRAC);
    else step = prod >> GAIN_FRAC;
    pos = longint'(cal.screen_center) + step;
    if (pos < 0) pos = 0;
    if (pos > COORD_MAX) pos = COORD_MAX;
    return SAMPLE_W'(pos);
  endfunction

  always @(posedge clk) begin : watch
    touch_point_t        want;
    logic [SAMPLE_W-1:0] smp;
    logic [SAMPLE_W-1:0] avg;
    if (rst) begin
      cal_x       = '{raw_center: RAW_CENTER_RST, gain: GAIN_RST, screen_center: SCREEN_X_RST};
      cal_y       = '{raw_center: RAW_CENTER_RST, gain: GAIN_RST, screen_center: SCREEN_Y_RST};
      burst_taken = 0;
      burst_sum   = 0;
      burst_max   = '0;
      burst_min   = '1;
      point_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RAW_CENTER_X:    cal_x.raw_center    = cfg_data[SAMPLE_W-1:0];
          REG_RAW_CENTER_Y:    cal_y.raw_center    = cfg_data[SAMPLE_W-1:0];
          REG_GAIN_X:          cal_x.gain          = cfg_data;
          REG_GAIN_Y:          cal_y.gain          = cfg_data;
          REG_SCREEN_CENTER_X: cal_x.screen_center = cfg_data[SAMPLE_W-1:0];
          REG_SCREEN_CENTER_Y: cal_y.screen_center = cfg_data[SAMPLE_W-1:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        if (point_q.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing expected: axis %0d mean %0d coord %0d",
                                  m_tuser, m_tdata[11:0], m_tdata[23:12]));
        end else begin
          want = point_q.pop_front();
          if (m_tuser !== want.axis || m_tdata[11:0] !== want.mean_raw ||
              m_tdata[23:12] !== want.coordinate) begin
            flag_mismatch($sformatf("got/exp axis %0d/%0d mean %0d/%0d coord %0d/%0d",
                                    m_tuser, want.axis, m_tdata[11:0], want.mean_raw,
                                    m_tdata[23:12], want.coordinate));
          end
        end
      end

      if (s_tvalid && s_tready) begin
        smp = s_tdata[SAMPLE_W-1:0];
        burst_sum += smp;
        if (smp > burst_max) burst_max = smp;
        if (smp < burst_min) burst_min = smp;
        burst_taken++;
        if (burst_taken == BURST_LEN) begin
          // axis of the closing beat picks the calibration set
          avg = SAMPLE_W'((burst_sum - burst_max - burst_min) / (BURST_LEN - 2));
          want.axis       = s_tuser;
          want.mean_raw   = avg;
          want.coordinate = screen_coord(avg, s_tuser ? cal_y : cal_x);
          point_q.push_back(want);
          burst_taken = 0;
          burst_sum   = 0;
          burst_max   = '0;
          burst_min   = '1;
        end
      end
    end
    outstanding <= point_q.size();
  end

endmodule

/* bench/touch_trimmed_mean_calibrator_top_tb.sv */
// Testbench top for touch_trimmed_mean_calibrator_top: clock, reset, sample and
// register stimulus, result back-pressure, watchdog and verdict.
// Depends on tmc_pkg and tmc_result_checker (bench/tmc_result_checker.sv).
module touch_trimmed_mean_calibrator_top_tb;
  import tmc_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 10;
  localparam int PHASES       = 7;
  localparam int BURSTS_EACH  = 19;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;   // [11:0] sample, rest zero
  logic                  s_tuser = 1'b0; // [0] axis
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [23:0]           m_tdata;        // [11:0] mean_raw, [23:12] coordinate
  logic                  m_tuser;        // [0] axis_out
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int stall_cycles = 0;
  int s_idle_odds  = 4;  // 1-in-N chance of a gap before a beat, 0 = never
  int m_idle_odds  = 5;
  bit no_idle      = 1'b0;
  bit hold_req     = 1'b0;

  always #5 clk = ~clk;

  touch_trimmed_mean_calibrator_top i_dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  tmc_result_checker i_checker (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .outstanding
  );

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("touch_trimmed_mean_calibrator_top_tb: FAIL");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!no_idle && m_idle_odds != 0 && $urandom_range(1, m_idle_odds) == 1) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic ax);
    if (!no_idle && s_idle_odds != 0 && $urandom_range(1, s_idle_odds) == 1) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, smp};
    s_tuser  <= ax;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // one burst: uniform, clustered, clustered with spikes, or pinned near the rails
  task automatic send_burst();
    int   style, base, span, k, v;
    logic ax;
    bit   mixed;
    style = $urandom_range(0, 3);
    ax    = 1'($urandom_range(0, 1));
    mixed = ($urandom_range(0, 9) == 0);
    base  = $urandom_range(0, 4095);
    span  = 1 << $urandom_range(0, 7);
    for (k = 0; k < BURST_LEN_DEF; k++) begin
      case (style)
        0: v = $urandom_range(0, 4095);
        1, 3: begin
          v = base + int'($urandom_range(0, span)) - span / 2;
          if (style == 3 && $urandom_range(0, 4) == 0) v = $urandom_range(0, 4095);
        end
        default: v = $urandom_range(0, 1) ? 4095 - int'($urandom_range(0, 3))
                                          : int'($urandom_range(0, 3));
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      if (mixed && $urandom_range(0, 3) == 0) ax = ~ax;
      send_sample(SAMPLE_W'(v), ax);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_calibration(input logic [15:0] rcx, input logic [15:0] rcy,
                                  input logic [15:0] gx, input logic [15:0] gy,
                                  input logic [15:0] scx, input logic [15:0] scy,
                                  input bit stray);
    logic [CFG_IDX_W-1:0] idx[8];
    logic [15:0]          val[8];
    int                   n, k;
    idx[0] = REG_RAW_CENTER_X;    val[0] = rcx;
    idx[1] = REG_RAW_CENTER_Y;    val[1] = rcy;
    idx[2] = REG_GAIN_X;          val[2] = gx;
    idx[3] = REG_GAIN_Y;          val[3] = gy;
    idx[4] = REG_SCREEN_CENTER_X; val[4] = scx;
    idx[5] = REG_SCREEN_CENTER_Y; val[5] = scy;
    // writes past the register list must leave everything unchanged
    idx[6] = REG_UNUSED_LO;       val[6] = 16'($urandom);
    idx[7] = REG_UNUSED_HI;       val[7] = 16'($urandom);
    n = stray ? 8 : 6;
    for (k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_gain();
    int g;
    g = $urandom_range(600, 4000);
    if ($urandom_range(0, 1)) g = -g;
    return 16'(g);
  endfunction

  initial begin
    logic [SAMPLE_W-1:0] opening_samples[15];
    logic                opening_axes[15];
    int                  p, b, k;
    // extremes, repeated maximum, alternating bit patterns, axis flipping mid-burst
    opening_samples = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd2048, 12'd1, 12'd4094,
                        12'h555, 12'hAAA, 12'd2047, 12'd2049, 12'd100, 12'd4000,
                        12'd7, 12'd4088};
    opening_axes    = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                        1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < 15; k++) send_sample(opening_samples[k], opening_axes[k]);

    for (p = 0; p < PHASES; p++) begin
      if (p > 0) drain_results();
      case (p)
        1: begin
          load_calibration(16'd0, 16'd4095, 16'h7FFF, 16'h7FFF, 16'd4095, 16'd0, 1'b0);
          s_idle_odds = 0; m_idle_odds = 3;
        end
        2: begin
          load_calibration(16'd2048, 16'd2048, 16'h8000, 16'h8000, 16'd2048, 16'd2048, 1'b0);
          s_idle_odds = 3; m_idle_odds = 0;
        end
        3: begin
          load_calibration(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)),
                           16'd0, 16'd0, 16'd4095, 16'd0, 1'b1);
          s_idle_odds = 0; m_idle_odds = 6;
        end
        4: begin
          // upper bits of the 12-bit registers are random and must be dropped
          load_calibration(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom), 1'b1);
          s_idle_odds = 6; m_idle_odds = 2;
        end
        5: begin
          load_calibration(16'($urandom_range(1500, 2600)), 16'($urandom_range(1500, 2600)),
                           pick_gain(), pick_gain(),
                           16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)), 1'b0);
          s_idle_odds = 2; m_idle_odds = 4;
        end
        6: begin
          load_calibration(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)),
                           pick_gain(), 16'($urandom),
                           16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)), 1'b1);
          no_idle = 1'b1;
        end
        default: ;
      endcase
      // receiver stalls long enough to back up the burst queue into the input
      if (p == 3) hold_req = 1'b1;
      for (b = 0; b < BURSTS_EACH; b++) begin
        send_burst();
        if (p == 4 && b == BURSTS_EACH / 2) drain_results();
      end
    end

    drain_results();
    if (mismatches == 0 && outstanding == 0)
      $display("touch_trimmed_mean_calibrator_top_tb: PASS");
    else
      $display("touch_trimmed_mean_calibrator_top_tb: FAIL");
    $finish;
  end

endmodule
